### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers used by the decoder top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define UPD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define UPD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/upd_pkg.sv
// ----------------------------------------------------------------------------
// URL percent decoder package
// Types, character codes and match phases shared by the decoder modules.
// ----------------------------------------------------------------------------
package upd_pkg;

	localparam int MAX_RESULTS = 3;
	localparam int QUEUE_DEPTH = 4;

	typedef logic [7:0] char_t;

	localparam char_t CH_PLUS  = 8'h2B;
	localparam char_t CH_PCT   = 8'h25;
	localparam char_t CH_SPACE = 8'h20;

	localparam logic [1:0] PHASE_IDLE = 2'd0;
	localparam logic [1:0] PHASE_PCT  = 2'd1;
	localparam logic [1:0] PHASE_HIGH = 2'd2;

	typedef struct packed {
		char_t ch;
		logic  eos;
	} in_item_t;

	typedef struct packed {
		char_t ch;
		logic  last;
	} res_ent_t;

	typedef struct packed {
		logic [1:0]                       cnt;
		res_ent_t [MAX_RESULTS-1:0]       ent;
	} dec_res_t;

	typedef struct packed {
		logic  emit;
		char_t ch;
		logic  to_pct;
	} fresh_t;

endpackage

### design/upd_in_if.sv
// ----------------------------------------------------------------------------
// Encoded byte channel
// Valid/ready channel carrying one encoded byte and its end-of-string flag.
// ----------------------------------------------------------------------------
interface upd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       end_of_string;

	modport source (output valid, output char_in, output end_of_string, input ready);
	modport sink (input valid, input char_in, input end_of_string, output ready);
endinterface

### design/upd_out_if.sv
// ----------------------------------------------------------------------------
// Decoded byte channel
// Valid/ready channel carrying one decoded byte and its last-byte flag.
// ----------------------------------------------------------------------------
interface upd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       out_last;

	modport source (output valid, output char_out, output out_last, input ready);
	modport sink (input valid, input char_out, input out_last, output ready);
endinterface

### design/upd_decode.sv
// ----------------------------------------------------------------------------
// URL percent decoder - decode stage
// Match phase state and the byte decode that yields zero to three results.
// ----------------------------------------------------------------------------
module upd_decode
	import upd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  in_item_t item,
	input  logic     advance,
	output dec_res_t res
);

	logic [1:0] phase_q;
	logic [2:0] held_q;
	logic [1:0] phase_d;
	logic [2:0] held_d;
	logic [1:0] n;
	fresh_t     fr;
	logic       hi_ok;
	logic       is_dig;
	logic       is_af;
	logic [3:0] lo_val;
	logic       lo_ok;

	function automatic fresh_t fresh(input char_t ch, input logic last);
		fresh_t f;
		f.emit   = 1'b1;
		f.ch     = ch;
		f.to_pct = 1'b0;
		if (ch == CH_PLUS) begin
			f.ch = CH_SPACE;
		end else if (ch == CH_PCT && !last) begin
			f.emit   = 1'b0;
			f.to_pct = 1'b1;
		end
		return f;
	endfunction

	always_comb begin
		fr     = fresh(item.ch, item.eos);
		hi_ok  = item.ch inside {[8'h32:8'h37]};
		is_dig = item.ch inside {[8'h30:8'h39]};
		is_af  = item.ch inside {[8'h41:8'h46]};
		lo_val = is_dig ? item.ch[3:0] : item.ch[3:0] + 4'd9;
		lo_ok  = (is_dig || is_af) && !(held_q == 3'd7 && lo_val == 4'hF);

		res     = '0;
		n       = '0;
		phase_d = PHASE_IDLE;
		held_d  = held_q;

		case (phase_q)
			PHASE_PCT: begin
				if (hi_ok) begin
					if (item.eos) begin
						res.ent[n].ch = CH_PCT;
						n = n + 2'd1;
						res.ent[n].ch = item.ch;
						n = n + 2'd1;
					end else begin
						held_d  = item.ch[2:0];
						phase_d = PHASE_HIGH;
					end
				end else begin
					res.ent[n].ch = CH_PCT;
					n = n + 2'd1;
					if (fr.emit) begin
						res.ent[n].ch = fr.ch;
						n = n + 2'd1;
					end
					if (fr.to_pct) phase_d = PHASE_PCT;
				end
			end
			PHASE_HIGH: begin
				if (lo_ok) begin
					res.ent[n].ch = {1'b0, held_q, lo_val};
					n = n + 2'd1;
				end else begin
					res.ent[n].ch = CH_PCT;
					n = n + 2'd1;
					res.ent[n].ch = {5'b00110, held_q};
					n = n + 2'd1;
					if (fr.emit) begin
						res.ent[n].ch = fr.ch;
						n = n + 2'd1;
					end
					if (fr.to_pct) phase_d = PHASE_PCT;
				end
			end
			default: begin
				if (fr.emit) begin
					res.ent[n].ch = fr.ch;
					n = n + 2'd1;
				end
				if (fr.to_pct) phase_d = PHASE_PCT;
			end
		endcase

		if (item.eos) begin
			phase_d = PHASE_IDLE;
			if (n != 2'd0) res.ent[n - 2'd1].last = 1'b1;
		end
		res.cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_IDLE;
			held_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

endmodule

### design/upd_queue.sv
// ----------------------------------------------------------------------------
// URL percent decoder - result queue
// Shifting queue that takes up to three results at once and emits one a cycle while out_ch.ready is high.
// ----------------------------------------------------------------------------
module upd_queue
	import upd_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
)
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  dec_res_t                    din,
	output logic [$clog2(QDEPTH+1)-1:0] count,
	upd_out_if.source                   out_ch
);

	localparam int CW = $clog2(QDEPTH + 1);
	localparam int AW = $clog2(QDEPTH);

	res_ent_t [QDEPTH-1:0] ent_q;
	res_ent_t [QDEPTH-1:0] ent_d;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_d;
	logic [CW-1:0]         base;
	logic [CW-1:0]         slot;
	logic                  pop;

	assign pop             = out_ch.valid && out_ch.ready;
	assign out_ch.valid    = count_q != '0;
	assign out_ch.char_out = ent_q[0].ch;
	assign out_ch.out_last = ent_q[0].last;
	assign count           = count_q;

	always_comb begin
		ent_d = ent_q;
		slot  = '0;
		if (pop) begin
			for (int i = 0; i < QDEPTH - 1; i++) ent_d[i] = ent_q[i+1];
		end
		base    = count_q - CW'(pop);
		count_d = base;
		if (push) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				slot = base + CW'(i);
				if (i < int'(din.cnt)) ent_d[slot[AW-1:0]] = din.ent[i];
			end
			count_d = base + CW'(din.cnt);
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else count_q <= count_d;
	end

endmodule

### design/url_percent_decoder_top.sv
// ----------------------------------------------------------------------------
// URL percent decoder - top level
// Streaming form decoder: '+' to space, %HH escapes of 20 to 7E (upper-case hex) to bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one encoded byte per request, with end_of_string on the last
//   byte of a string. out_ch gives decoded bytes, out_last on the final one.
//   A byte yields zero to three decoded bytes; a '%' or a high digit that may
//   start an escape is held until the byte that settles it arrives.
//   A result passes the input register, then the result queue register, before
//   it shows on out_ch. Throughput: one byte per cycle while each byte yields
//   at most one result and the receiver is ready.
//   The result queue holds QDEPTH entries and takes a decoded byte group only
//   while at most QDEPTH-3 entries are filled, so a three-result burst from
//   a broken escape stalls the input until the queue drains to QDEPTH-3 entries.
//   Reset clears the match phase and empties the input register and queue.
//   When the receiver stalls the queue fills and in_ch.ready drops; nothing
//   is lost, and in_ch.ready never depends on out_ch.ready in the same cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module url_percent_decoder_top
	import upd_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
)
(
	input  logic      clk,
	input  logic      arst_n,
	upd_in_if.sink    in_ch,
	upd_out_if.source out_ch
);

	localparam int CW = $clog2(QDEPTH + 1);

	in_item_t      item_s1;
	logic          valid_s1;
	logic          push;
	logic          can_push;
	logic [CW-1:0] count;
	dec_res_t      res;

	assign can_push    = count <= CW'(QDEPTH - MAX_RESULTS);
	assign push        = valid_s1 && can_push;
	assign in_ch.ready = !valid_s1 || push;

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.ch  <= in_ch.char_in;
			item_s1.eos <= in_ch.end_of_string;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (in_ch.valid && in_ch.ready) valid_s1 <= 1'b1;
		else if (push) valid_s1 <= 1'b0;
	end

	upd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.advance (push),
		.res     (res)
	);

	upd_queue #(
		.QDEPTH (QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (res),
		.count  (count),
		.out_ch (out_ch)
	);

	`UPD_ASSERT_IMP(a_queue_bound, 1'b1, count <= CW'(QDEPTH), "result queue overflow")
	`UPD_ASSERT_IMP(a_eos_marked, push && item_s1.eos, res.cnt != 2'd0, "string end not marked")
	`UPD_ASSERT_NXT(a_hold_s1, valid_s1 && !push, valid_s1, "held request dropped")

endmodule
